@@ rtl/utf8_decoder_with_cjk_flag_defines.svh @@
// ---------------------------------------------------------------------------
// utf8 decoder assertion macros
// shared concurrent assertion forms for the decoder rtl
// ---------------------------------------------------------------------------
`ifndef UTF8_DECODER_WITH_CJK_FLAG_DEFINES_SVH
`define UTF8_DECODER_WITH_CJK_FLAG_DEFINES_SVH

// same-cycle implication
`define U8D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8dec assertion failed");

// next-cycle implication
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8dec assertion failed");

`endif

@@ rtl/u8dec_pkg.sv @@
// ---------------------------------------------------------------------------
// u8dec_pkg
// word types, status codes and cjk range limits for the utf8 decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

    localparam int CP_W = 21;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [1:0] ST_BAD_CONT = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    localparam logic [CP_W-1:0] CJK_A_LO  = 21'h03400;
    localparam logic [CP_W-1:0] CJK_A_HI  = 21'h04DBF;
    localparam logic [CP_W-1:0] CJK_U_LO  = 21'h04E00;
    localparam logic [CP_W-1:0] CJK_U_HI  = 21'h09FFF;
    localparam logic [CP_W-1:0] CJK_B_LO  = 21'h20000;
    localparam logic [CP_W-1:0] CJK_B_HI  = 21'h2A6DF;
    localparam logic [CP_W-1:0] CJK_CF_LO = 21'h2A700;
    localparam logic [CP_W-1:0] CJK_CF_HI = 21'h2CEAF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } byte_word_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [1:0]      status;
        logic            is_cjk;
        logic            last_of_string;
    } cp_word_t;

endpackage

`default_nettype wire

@@ rtl/utf8_decoder_with_cjk_flag.sv @@
// ---------------------------------------------------------------------------
// utf8_decoder_with_cjk_flag
// streaming utf8 decoder with a cjk ideograph flag on each code point
// ---------------------------------------------------------------------------
// Takes one byte per cycle and returns each finished code point, or one error
// word per failed string; the byte that completes it passes the input register
// and then the result register before its word appears. Bytes that only
// open or extend a sequence, and bytes dropped after an error, give no word.
// A byte can be taken every cycle; the input is held only while a byte waits
// in the input register behind a stalled result register that is already full.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_decoder_with_cjk_flag_defines.svh"

module utf8_decoder_with_cjk_flag (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_valid,
    output logic                       byte_stall,
    input  wire u8dec_pkg::byte_word_t byte_word,
    output logic                       cp_valid,
    input  wire logic                  cp_stall,
    output u8dec_pkg::cp_word_t        cp_word
);
    import u8dec_pkg::*;

    logic            s1_valid_reg;
    byte_word_t      s1_word_reg;
    logic            advance;
    logic            s1_load;

    logic [1:0]      pending_reg, pending_next;
    logic [CP_W-1:0] partial_reg, partial_next;
    logic            dropping_reg, dropping_next;

    logic            emit;
    logic [1:0]      status;
    logic [CP_W-1:0] cp_raw;
    logic            cjk_hit;
    logic [1:0]      pend_dec;
    logic [CP_W-1:0] cont_bits;
    logic [7:0]      b;
    logic            last;

    logic            out_valid_reg, out_valid_next;
    cp_word_t        out_word_reg, out_word_next;

    assign advance    = !out_valid_reg || !cp_stall;
    assign s1_load    = advance || !s1_valid_reg;
    assign byte_stall = s1_valid_reg && !advance;
    assign b          = s1_word_reg.data_byte;
    assign last       = s1_word_reg.end_of_string;
    assign pend_dec   = pending_reg - 2'd1;

    always_comb
    begin
        unique case (pend_dec)
            2'd0:    cont_bits = {15'd0, b[5:0]};
            2'd1:    cont_bits = {9'd0, b[5:0], 6'd0};
            default: cont_bits = {3'd0, b[5:0], 12'd0};
        endcase
    end

    always_comb
    begin
        pending_next  = pending_reg;
        partial_next  = partial_reg;
        dropping_next = dropping_reg;
        emit          = 1'b0;
        status        = ST_OK;
        cp_raw        = '0;
        if (dropping_reg)
        begin
            if (last)
            begin
                dropping_next = 1'b0;
                pending_next  = 2'd0;
                partial_next  = '0;
            end
        end
        else if (pending_reg == 2'd0)
        begin
            if (!b[7])
            begin
                emit   = 1'b1;
                cp_raw = {13'd0, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                partial_next = {10'd0, b[4:0], 6'd0};
                pending_next = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                partial_next = {5'd0, b[3:0], 12'd0};
                pending_next = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                partial_next = {b[2:0], 18'd0};
                pending_next = 2'd3;
            end
            else
            begin
                emit          = 1'b1;
                status        = ST_BAD_LEAD;
                pending_next  = 2'd0;
                partial_next  = '0;
                dropping_next = !last;
            end
            if (b[7:6] == 2'b11 && b[7:3] != 5'b11111 && last)
            begin
                emit          = 1'b1;
                status        = ST_TRUNC;
                pending_next  = 2'd0;
                partial_next  = '0;
                dropping_next = 1'b0;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            emit          = 1'b1;
            status        = ST_BAD_CONT;
            pending_next  = 2'd0;
            partial_next  = '0;
            dropping_next = !last;
        end
        else if (pend_dec == 2'd0)
        begin
            emit         = 1'b1;
            cp_raw       = partial_reg | cont_bits;
            pending_next = 2'd0;
            partial_next = '0;
        end
        else if (last)
        begin
            emit          = 1'b1;
            status        = ST_TRUNC;
            pending_next  = 2'd0;
            partial_next  = '0;
            dropping_next = 1'b0;
        end
        else
        begin
            pending_next = pend_dec;
            partial_next = partial_reg | cont_bits;
        end
    end

    u8dec_cjk u_cjk (
        .code_point (cp_raw),
        .hit        (cjk_hit)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (advance)
        begin
            out_valid_next                = s1_valid_reg && emit;
            out_word_next.code_point      = cp_raw;
            out_word_next.status          = status;
            out_word_next.is_cjk          = (status == ST_OK) && cjk_hit;
            out_word_next.last_of_string  = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pending_reg   <= 2'd0;
            partial_reg   <= '0;
            dropping_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= byte_valid;
            end
            if (advance && s1_valid_reg)
            begin
                pending_reg  <= pending_next;
                partial_reg  <= partial_next;
                dropping_reg <= dropping_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && byte_valid)
        begin
            s1_word_reg <= byte_word;
        end
        out_word_reg <= out_word_next;
    end

    assign cp_valid = out_valid_reg;
    assign cp_word  = out_word_reg;

    `U8D_ASSERT_SAME(a_err_zero, clk, rst_n,
        cp_valid && cp_word.status != ST_OK,
        cp_word.code_point == '0 && !cp_word.is_cjk)
    `U8D_ASSERT_SAME(a_trunc_last, clk, rst_n,
        cp_valid && cp_word.status == ST_TRUNC, cp_word.last_of_string)
    `U8D_ASSERT_SAME(a_drop_clean, clk, rst_n,
        dropping_reg, pending_reg == 2'd0 && partial_reg == '0)
    `U8D_ASSERT_SAME(a_idle_clean, clk, rst_n,
        pending_reg == 2'd0, partial_reg == '0)
    `U8D_ASSERT_NEXT(a_last_resets, clk, rst_n,
        advance && s1_valid_reg && s1_word_reg.end_of_string,
        pending_reg == 2'd0 && !dropping_reg)

endmodule

`default_nettype wire

@@ rtl/u8dec_cjk.sv @@
// ---------------------------------------------------------------------------
// u8dec_cjk
// flags code points that fall in the cjk unified ideograph ranges
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8dec_cjk (
    input  wire logic [u8dec_pkg::CP_W-1:0] code_point,
    output logic                            hit
);
    import u8dec_pkg::*;

    always_comb
    begin
        hit = ((code_point >= CJK_A_LO)  && (code_point <= CJK_A_HI))  ||
              ((code_point >= CJK_U_LO)  && (code_point <= CJK_U_HI))  ||
              ((code_point >= CJK_B_LO)  && (code_point <= CJK_B_HI))  ||
              ((code_point >= CJK_CF_LO) && (code_point <= CJK_CF_HI));
    end

endmodule

`default_nettype wire
